@@ src/ipv6_upper_layer_checksum_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the IPv6 upper-layer checksum core
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef IPV6_UPPER_LAYER_CHECKSUM_CORE_ASSERT_SVH
`define IPV6_UPPER_LAYER_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CK_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum core check failed");

// Next-cycle implication, disabled during reset.
`define CK_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum core check failed");

`endif

@@ src/ipv6ck_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv6ck_pkg
// Types and constants shared by the IPv6 upper-layer checksum core.
// ----------------------------------------------------------------------------
package ipv6ck_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W            = (POS_W > 17) ? POS_W : 17;
    localparam int SUM_W            = 32;
    localparam int TOT_W            = SUM_W + 2;
    localparam int ADDR_START       = 8;
    localparam int ADDR_END         = 40;
    localparam int MIN_PSEUDO_LEN   = 40;

    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic        is_first;
        logic        is_last;
        logic [7:0]  next_header;
        logic [15:0] seg_offset;
        logic [15:0] seg_length;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic        error;
    } out_beat_t;

    // Packet totals captured on the last byte
    typedef struct packed {
        logic [SUM_W-1:0] seg_sum;
        logic [SUM_W-1:0] addr_sum;
        logic [7:0]       protocol;
        logic [15:0]      offset;
        logic [15:0]      length;
        logic [POS_W-1:0] position;
    } snap_t;

endpackage

@@ src/ipv6_upper_layer_checksum_core.sv @@
// ----------------------------------------------------------------------------
// ipv6_upper_layer_checksum_core
// IPv6 upper-layer (pseudo header) Internet checksum over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   pkt channel: one packet byte per beat, starting at the first IPv6 header
//   byte. The beat with is_first set also carries next_header, seg_offset
//   and seg_length, which stay latched for the packet. The beat with is_last
//   set closes the packet and produces one result beat.
//   res channel: checksum and error, one beat per packet.
// Throughput: one byte per cycle while pkt_ready is high; the running sums
//   take a single add per byte, so back-to-back beats and packets are accepted.
// Result path: the snapshot, the pseudo-header add, then the carry fold and
//   invert, each registered in turn after the last byte is accepted.
// Reset: sums, byte position and latched fields clear; the result pipeline
//   empties.
// Stall: a result waiting on res_ready holds unchanged. Up to three finished
//   packets queue in the result pipeline; pkt_ready drops only when all three
//   are occupied.
// ----------------------------------------------------------------------------
module ipv6_upper_layer_checksum_core
    import ipv6ck_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_ready,
    input  in_beat_t  pkt_data,
    output logic      res_valid,
    input  logic      res_ready,
    output out_beat_t res_data
);

    logic  snap_valid;
    logic  snap_ready;
    snap_t snap_data;

    ipv6ck_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt_data   (pkt_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data)
    );

    ipv6ck_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

@@ src/ipv6ck_acc.sv @@
// ----------------------------------------------------------------------------
// ipv6ck_acc
// Per-byte accumulator: segment words, address words, byte position, and a
// snapshot register loaded on the last byte of a packet.
// ----------------------------------------------------------------------------
module ipv6ck_acc
    import ipv6ck_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pkt_valid,
    output logic     pkt_ready,
    input  in_beat_t pkt_data,
    output logic     snap_valid,
    input  logic     snap_ready,
    output snap_t    snap_data
);

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_ADDR0 = POS_W'(ADDR_START);
    localparam logic [POS_W-1:0] POS_ADDR1 = POS_W'(ADDR_END);

    logic [SUM_W-1:0] seg_sum_reg,  seg_sum_next;
    logic [SUM_W-1:0] addr_sum_reg, addr_sum_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       held_reg,     held_next;
    logic [15:0]      afw_reg,      afw_next;
    logic [7:0]       proto_reg,    proto_next;
    logic [15:0]      offset_reg,   offset_next;
    logic [15:0]      length_reg,   length_next;
    logic             snap_valid_reg;
    snap_t            snap_reg;

    logic [SUM_W-1:0] seg_base, addr_base, part;
    logic [POS_W-1:0] pos_base;
    logic [7:0]       held_base;
    logic [15:0]      afw_base;
    logic [3:0]       addr_idx;
    logic [CMP_W-1:0] rel;
    logic             accept;

    // Link-local unicast, link-local or interface-local multicast
    function automatic logic scoped(input logic [15:0] w0);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = w0[15:8];
        lo = w0[7:0];
        return (hi == 8'hfe && lo[7:6] == 2'b10) ||
               (hi == 8'hff && (lo[3:0] == 4'h2 || lo[3:0] == 4'h1));
    endfunction

    assign pkt_ready  = !snap_valid_reg || snap_ready;
    assign accept     = pkt_valid && pkt_ready;
    assign snap_valid = snap_valid_reg;
    assign snap_data  = snap_reg;

    always_comb
    begin
        proto_next  = pkt_data.is_first ? pkt_data.next_header : proto_reg;
        offset_next = pkt_data.is_first ? pkt_data.seg_offset  : offset_reg;
        length_next = pkt_data.is_first ? pkt_data.seg_length  : length_reg;
        seg_base    = pkt_data.is_first ? '0 : seg_sum_reg;
        addr_base   = pkt_data.is_first ? '0 : addr_sum_reg;
        pos_base    = pkt_data.is_first ? '0 : pos_reg;
        held_base   = pkt_data.is_first ? '0 : held_reg;
        afw_base    = pkt_data.is_first ? '0 : afw_reg;

        seg_sum_next  = seg_base;
        addr_sum_next = addr_base;
        pos_next      = pos_base;
        held_next     = held_base;
        afw_next      = afw_base;

        // byte index within the current 16-byte address
        addr_idx = {~pos_base[3], pos_base[2:0]};
        part     = pos_base[0] ? SUM_W'(pkt_data.pkt_byte)
                               : SUM_W'({pkt_data.pkt_byte, 8'h00});
        rel      = CMP_W'(pos_base) - CMP_W'(offset_next);

        if (pos_base < POS_MAX)
        begin
            if (pos_base >= POS_ADDR0 && pos_base < POS_ADDR1)
            begin
                if (addr_idx < 4'd2)
                begin
                    afw_next = pos_base[0] ? (afw_base | {8'h00, pkt_data.pkt_byte})
                                           : {pkt_data.pkt_byte, 8'h00};
                    addr_sum_next = addr_base + part;
                end
                else if (addr_idx < 4'd4)
                begin
                    if (!scoped(afw_base))
                        addr_sum_next = addr_base + part;
                end
                else
                begin
                    addr_sum_next = addr_base + part;
                end
            end

            if (CMP_W'(pos_base) >= CMP_W'(offset_next) && rel < CMP_W'(length_next))
            begin
                if (!rel[0])
                begin
                    held_next = pkt_data.pkt_byte;
                    // odd segment length: pad the final byte
                    if (rel + CMP_W'(1) == CMP_W'(length_next))
                        seg_sum_next = seg_base + SUM_W'({pkt_data.pkt_byte, 8'h00});
                end
                else
                begin
                    seg_sum_next = seg_base + SUM_W'({held_base, pkt_data.pkt_byte});
                end
            end

            pos_next = pos_base + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_sum_reg    <= '0;
            addr_sum_reg   <= '0;
            pos_reg        <= '0;
            held_reg       <= '0;
            afw_reg        <= '0;
            proto_reg      <= '0;
            offset_reg     <= '0;
            length_reg     <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                proto_reg  <= proto_next;
                offset_reg <= offset_next;
                length_reg <= length_next;
                if (pkt_data.is_last)
                begin
                    // drop the packet state once its totals are captured
                    seg_sum_reg  <= '0;
                    addr_sum_reg <= '0;
                    pos_reg      <= '0;
                    held_reg     <= '0;
                    afw_reg      <= '0;
                end
                else
                begin
                    seg_sum_reg  <= seg_sum_next;
                    addr_sum_reg <= addr_sum_next;
                    pos_reg      <= pos_next;
                    held_reg     <= held_next;
                    afw_reg      <= afw_next;
                end
            end

            if (accept && pkt_data.is_last)
                snap_valid_reg <= 1'b1;
            else if (snap_ready)
                snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pkt_data.is_last)
        begin
            snap_reg.seg_sum  <= seg_sum_next;
            snap_reg.addr_sum <= addr_sum_next;
            snap_reg.protocol <= proto_next;
            snap_reg.offset   <= offset_next;
            snap_reg.length   <= length_next;
            snap_reg.position <= pos_next;
        end
    end

endmodule

@@ src/ipv6ck_fold.sv @@
// ----------------------------------------------------------------------------
// ipv6ck_fold
// Adds the pseudo header to the segment sum for a nonzero protocol, checks the
// packet length, then folds the carries and inverts in a second stage.
// ----------------------------------------------------------------------------
module ipv6ck_fold
    import ipv6ck_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      snap_valid,
    output logic      snap_ready,
    input  snap_t     snap_data,
    output logic      res_valid,
    input  logic      res_ready,
    output out_beat_t res_data
);

    logic             tot_valid_reg;
    logic [TOT_W-1:0] tot_reg;
    logic             err_reg;
    logic             out_valid_reg;
    out_beat_t        out_reg;

    logic             out_free, tot_free;
    logic             has_pseudo, err_now;
    logic [CMP_W-1:0] need;
    logic [TOT_W-1:0] total;
    logic [18:0]      fold1;
    logic [16:0]      fold2;
    logic [15:0]      fold3;

    assign out_free   = !out_valid_reg || res_ready;
    assign tot_free   = !tot_valid_reg || out_free;
    assign snap_ready = tot_free;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;

    always_comb
    begin
        has_pseudo = snap_data.protocol != 8'h00;
        need       = CMP_W'(snap_data.offset) + CMP_W'(snap_data.length);
        err_now    = CMP_W'(snap_data.position) < need ||
                     (has_pseudo && CMP_W'(snap_data.position) < CMP_W'(MIN_PSEUDO_LEN));
        total      = TOT_W'(snap_data.seg_sum);
        if (has_pseudo)
            total = total + TOT_W'(snap_data.addr_sum) + TOT_W'(snap_data.protocol)
                          + TOT_W'(snap_data.length);

        // end-around carry until the sum fits in 16 bits
        fold1 = 19'(tot_reg[15:0]) + 19'(tot_reg[TOT_W-1:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[18:16]);
        fold3 = fold2[15:0] + 16'(fold2[16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tot_free)
                tot_valid_reg <= snap_valid;
            if (out_free)
                out_valid_reg <= tot_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tot_free && snap_valid)
        begin
            tot_reg <= total;
            err_reg <= err_now;
        end
        if (out_free && tot_valid_reg)
        begin
            out_reg.checksum <= err_reg ? 16'h0000 : ~fold3;
            out_reg.error    <= err_reg;
        end
    end

endmodule

@@ src/ipv6ck_checker.sv @@
// ----------------------------------------------------------------------------
// ipv6ck_checker
// Port-level checks for the checksum core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ipv6_upper_layer_checksum_core_assert.svh"

module ipv6ck_checker
    import ipv6ck_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pkt_valid,
    input logic      pkt_ready,
    input in_beat_t  pkt_data,
    input logic      res_valid,
    input logic      res_ready,
    input out_beat_t res_data
);

    // hold a stalled result beat
    `CK_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

    // an errored packet reports a zero checksum
    `CK_ASSERT_IMPLY(a_err_zero, res_valid && res_data.error, res_data.checksum == 16'h0000)

    // with the receiver ready, an accepted last byte reaches a valid output
    `CK_ASSERT_NEXT(a_latency, pkt_valid && pkt_ready && pkt_data.is_last ##1 res_ready ##1 res_ready, res_valid)

endmodule

bind ipv6_upper_layer_checksum_core ipv6ck_checker u_checker (.*);

@@ test/tb_ipv6_upper_layer_checksum_core.sv @@
// ----------------------------------------------------------------------------
// tb_ipv6_upper_layer_checksum_core
// Byte-stream checksum bench: feeds IPv6 packets one byte per beat, predicts
// the pseudo-header Internet checksum in the bench and compares every result
// beat against it, under random idling on both channels and a long stall.
// ----------------------------------------------------------------------------
module tb_ipv6_upper_layer_checksum_core;
    import ipv6ck_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;

    logic      clk;
    logic      rst_n;
    logic      pkt_valid;
    logic      pkt_ready;
    in_beat_t  pkt_data;
    logic      res_valid;
    logic      res_ready;
    out_beat_t res_data;

    // Checksum predictor state
    logic [31:0] seg_sum;
    logic [31:0] addr_sum;
    int unsigned byte_pos;
    logic [7:0]  held_hi;
    logic [15:0] addr_word0;
    logic [7:0]  lat_proto;
    logic [15:0] lat_off;
    logic [15:0] lat_len;

    out_beat_t   pending_checksums[$];
    logic [7:0]  frame_q[$];

    bit          idle_on;
    bit          long_stall_pending;
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned results_predicted;
    int unsigned results_checked;
    int unsigned error_results;

    ipv6_upper_layer_checksum_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt_data  (pkt_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("%0t: timeout, %0d checksums still outstanding",
                 $time, pending_checksums.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit is_scoped_word(logic [15:0] w);
        if (w[15:8] == 8'hfe && w[7:6] == 2'b10)
            return 1'b1;
        if (w[15:8] == 8'hff && (w[3:0] == 4'h1 || w[3:0] == 4'h2))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] fold_carries(logic [63:0] x);
        while (x[63:16] != 0)
            x = {48'h0, x[15:0]} + {16'h0, x[63:16]};
        return x[15:0];
    endfunction

    function automatic void clear_packet_sums();
        seg_sum    = '0;
        addr_sum   = '0;
        byte_pos   = 0;
        held_hi    = '0;
        addr_word0 = '0;
    endfunction

    // Advance the predicted packet state by one accepted beat.
    function automatic void accumulate_checksum(in_beat_t b);
        int unsigned k;
        int unsigned i;
        int unsigned need;
        logic [15:0] part;
        logic [63:0] total;
        bit          err;
        out_beat_t   r;

        if (b.is_first)
        begin
            clear_packet_sums();
            lat_proto = b.next_header;
            lat_off   = b.seg_offset;
            lat_len   = b.seg_length;
        end

        if (byte_pos < MAX_PACKET_BYTES)
        begin
            if (byte_pos >= ADDR_START && byte_pos < ADDR_END)
            begin
                k    = (byte_pos - ADDR_START) & 15;
                part = (k & 1) ? {8'h00, b.pkt_byte} : {b.pkt_byte, 8'h00};
                if (k < 2)
                begin
                    addr_word0 = (k & 1) ? (addr_word0 | {8'h00, b.pkt_byte})
                                         : {b.pkt_byte, 8'h00};
                    addr_sum   = addr_sum + {16'h0, part};
                end
                else if (k < 4)
                begin
                    // drop word 1 of a link-local or interface-local address
                    if (!is_scoped_word(addr_word0))
                        addr_sum = addr_sum + {16'h0, part};
                end
                else
                    addr_sum = addr_sum + {16'h0, part};
            end

            if (byte_pos >= lat_off && byte_pos - lat_off < lat_len)
            begin
                i = byte_pos - lat_off;
                if ((i & 1) == 0)
                begin
                    held_hi = b.pkt_byte;
                    if (i + 1 == lat_len)
                        seg_sum = seg_sum + {16'h0, b.pkt_byte, 8'h00};
                end
                else
                    seg_sum = seg_sum + {16'h0, held_hi, b.pkt_byte};
            end
            byte_pos = byte_pos + 1;
        end

        if (b.is_last)
        begin
            need  = lat_off + lat_len;
            err   = (byte_pos < need) || (lat_proto != 0 && byte_pos < MIN_PSEUDO_LEN);
            total = {32'h0, seg_sum};
            if (lat_proto != 0)
                total = total + {32'h0, addr_sum} + lat_proto + lat_len;
            r.checksum = err ? 16'h0000 : ~fold_carries(total);
            r.error    = err;
            pending_checksums.push_back(r);
            results_predicted++;
            clear_packet_sums();
        end
    endfunction

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_beat(in_beat_t b);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pkt_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        pkt_valid <= 1'b1;
        pkt_data  <= b;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        accumulate_checksum(b);
        bytes_sent++;
    endtask

    task automatic build_frame(int unsigned total, logic [15:0] src_w0, logic [15:0] dst_w0);
        int unsigned j;
        frame_q.delete();
        for (j = 0; j < total; j++)
            frame_q.push_back(8'($urandom_range(0, 255)));
        if (total > 9)
        begin
            frame_q[8] = src_w0[15:8];
            frame_q[9] = src_w0[7:0];
        end
        if (total > 25)
        begin
            frame_q[24] = dst_w0[15:8];
            frame_q[25] = dst_w0[7:0];
        end
    endtask

    task automatic send_frame(logic [7:0] nh, logic [15:0] off, logic [15:0] len,
                              bit with_first);
        int unsigned j;
        int unsigned n;
        in_beat_t    b;
        n = frame_q.size();
        for (j = 0; j < n; j++)
        begin
            b.pkt_byte = frame_q[j];
            b.is_first = with_first && (j == 0);
            b.is_last  = (j == n - 1);
            // latched only on the first beat; scramble them elsewhere
            b.next_header = (j == 0) ? nh  : 8'($urandom_range(0, 255));
            b.seg_offset  = (j == 0) ? off : 16'($urandom);
            b.seg_length  = (j == 0) ? len : 16'($urandom);
            send_beat(b);
        end
        packets_sent++;
    endtask

    function automatic logic [15:0] pick_addr_word();
        case ($urandom_range(0, 4))
            0: return {8'hfe, 2'b10, 6'($urandom_range(0, 63))};
            1: return {8'hff, 4'($urandom_range(0, 15)), ($urandom_range(0, 1) ? 4'h1 : 4'h2)};
            2: return {8'hfe, 2'b11, 6'($urandom_range(0, 63))};
            3: return {8'hff, 4'($urandom_range(0, 15)), 4'h8};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_protocol();
        case ($urandom_range(0, 3))
            0: return 8'd6;
            1: return 8'd17;
            2: return 8'd58;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Result side: random stall bursts plus one long hold-off on request.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_pending)
            begin
                long_stall_pending = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                res_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_checked++;
            if (res_data.error)
                error_results++;
            if (pending_checksums.size() == 0)
            begin
                $display("%0t: unexpected result beat checksum=%04h error=%0d",
                         $time, res_data.checksum, res_data.error);
                mismatch_count++;
            end
            else
            begin
                want = pending_checksums.pop_front();
                if (res_data.checksum !== want.checksum)
                begin
                    $display("%0t: checksum mismatch expected=%04h actual=%04h",
                             $time, want.checksum, res_data.checksum);
                    mismatch_count++;
                end
                if (res_data.error !== want.error)
                begin
                    $display("%0t: error flag mismatch expected=%0d actual=%0d",
                             $time, want.error, res_data.error);
                    mismatch_count++;
                end
            end
        end
    end

    // Unmarked packets reuse the last latched fields, zero straight after reset.
    task automatic test_missing_first_marker();
        build_frame(3, 16'h0, 16'h0);
        send_frame(8'd0, 16'd0, 16'd0, 1'b0);
        build_frame(44, 16'h2001, 16'h2001);
        send_frame(8'd17, 16'd40, 16'd4, 1'b1);
        build_frame(44, 16'hfe80, 16'h2001);
        send_frame(8'd0, 16'd0, 16'd0, 1'b0);
    endtask

    task automatic test_single_byte_packets();
        frame_q = '{8'hff};
        send_frame(8'd0, 16'd0, 16'd1, 1'b1);
        frame_q = '{8'h00};
        send_frame(8'd0, 16'd0, 16'd0, 1'b1);
        frame_q = '{8'h5a};
        send_frame(8'd0, 16'd0, 16'd2, 1'b1);
        frame_q = '{8'hff};
        send_frame(8'hff, 16'hffff, 16'hffff, 1'b1);
    endtask

    task automatic test_pseudo_header();
        build_frame(48, 16'h2001, 16'h2607);
        send_frame(8'd17, 16'd40, 16'd8, 1'b1);
        build_frame(47, 16'h2001, 16'hfd00);
        send_frame(8'hff, 16'd40, 16'd7, 1'b1);
        build_frame(40, 16'hfe80, 16'hff02);
        send_frame(8'd0, 16'd0, 16'd40, 1'b1);
    endtask

    task automatic test_scoped_addresses();
        build_frame(40, 16'hfe80, 16'hff02);
        send_frame(8'd58, 16'd32, 16'd8, 1'b1);
        build_frame(40, 16'hff01, 16'hfebf);
        send_frame(8'd58, 16'd40, 16'd0, 1'b1);
        build_frame(40, 16'hfec0, 16'hff0e);
        send_frame(8'd58, 16'd0, 16'd0, 1'b1);
        build_frame(42, 16'hff12, 16'hfe80);
        send_frame(8'd6, 16'd40, 16'd2, 1'b1);
    endtask

    task automatic test_segment_shapes();
        // segment covering the header, odd tail
        build_frame(41, 16'h2001, 16'hfe80);
        send_frame(8'd6, 16'd0, 16'd41, 1'b1);
        // offset beyond length
        build_frame(48, 16'h2001, 16'h2001);
        send_frame(8'd6, 16'd45, 16'd3, 1'b1);
        build_frame(48, 16'hffff, 16'hffff);
        foreach (frame_q[j])
            frame_q[j] = 8'hff;
        send_frame(8'hff, 16'd8, 16'd40, 1'b1);
    endtask

    task automatic test_short_packets();
        build_frame(39, 16'h2001, 16'h2001);
        send_frame(8'd6, 16'd0, 16'd0, 1'b1);
        build_frame(39, 16'h2001, 16'h2001);
        send_frame(8'd0, 16'd0, 16'd39, 1'b1);
        build_frame(50, 16'h2001, 16'h2001);
        send_frame(8'd17, 16'd40, 16'd11, 1'b1);
    endtask

    task automatic test_result_backpressure();
        int unsigned j;
        idle_on            = 1'b1;
        long_stall_pending = 1'b1;
        for (j = 0; j < 12; j++)
        begin
            build_frame($urandom_range(1, 3), 16'h0, 16'h0);
            send_frame(8'd0, 16'd0, 16'($urandom_range(0, 3)), 1'b1);
        end
    endtask

    task automatic test_random_traffic(int unsigned min_beats, int unsigned min_results,
                                       bit with_idle);
        int unsigned beats0;
        int unsigned results0;
        int unsigned total;
        int unsigned off;
        int unsigned sel;
        int unsigned j;
        in_beat_t    b;
        beats0   = bytes_sent;
        results0 = results_predicted;
        while (bytes_sent - beats0 < min_beats || results_predicted - results0 < min_results)
        begin
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            sel     = $urandom_range(0, 99);
            if (sel < 30)
            begin
                total = $urandom_range(40, 56);
                off   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total) : 40;
                build_frame(total, pick_addr_word(), pick_addr_word());
                send_frame(pick_protocol(), 16'(off),
                           16'($urandom_range(0, 4) == 0 ? $urandom_range(0, total - off)
                                                         : total - off), 1'b1);
            end
            else if (sel < 80)
            begin
                total = $urandom_range(1, 16);
                off   = $urandom_range(0, total);
                build_frame(total, 16'h0, 16'h0);
                send_frame(8'd0, 16'(off), 16'($urandom_range(0, total - off)), 1'b1);
            end
            else if (sel < 90)
            begin
                // broken packet: truncated header, wild fields, maybe no start mark
                build_frame($urandom_range(1, 39), pick_addr_word(), pick_addr_word());
                send_frame(8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                           $urandom_range(0, 1));
            end
            else
            begin
                for (j = $urandom_range(1, 5); j > 0; j--)
                begin
                    b.pkt_byte    = 8'($urandom_range(0, 255));
                    b.is_first    = 1'($urandom_range(0, 1));
                    b.is_last     = 1'($urandom_range(0, 1));
                    b.next_header = 8'($urandom_range(0, 255));
                    b.seg_offset  = 16'($urandom);
                    b.seg_length  = 16'($urandom);
                    send_beat(b);
                end
            end
        end
    endtask

    initial
    begin
        pkt_valid          = 1'b0;
        pkt_data           = '0;
        rst_n              = 1'b0;
        idle_on            = 1'b1;
        long_stall_pending = 1'b0;
        mismatch_count     = 0;
        bytes_sent         = 0;
        packets_sent       = 0;
        results_predicted  = 0;
        results_checked    = 0;
        error_results      = 0;
        clear_packet_sums();
        lat_proto = '0;
        lat_off   = '0;
        lat_len   = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_missing_first_marker();
        test_single_byte_packets();
        test_pseudo_header();
        test_scoped_addresses();
        test_segment_shapes();
        test_short_packets();
        test_result_backpressure();
        test_random_traffic(100, 6, 1'b1);
        test_random_traffic(40, 2, 1'b0);

        @(negedge clk);
        pkt_valid <= 1'b0;
        while (pending_checksums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d packets; %0d results checked, %0d flagged short.",
                 bytes_sent, packets_sent, results_checked, error_results);
        $display("Mix: scoped and global addresses, odd and overlapping segments, a long stall.");
        if (mismatch_count == 0 && pending_checksums.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/ipv6ck_pkg.sv
src/ipv6ck_acc.sv
src/ipv6ck_fold.sv
src/ipv6_upper_layer_checksum_core.sv
src/ipv6ck_checker.sv
test/tb_ipv6_upper_layer_checksum_core.sv
